// File: rtl/crsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared types and constants of the CRSF frame receiver.
// ----------------------------------------------------------------------------
package crsf_pkg;

  // Byte positions and frame totals never exceed 64.
  localparam int POS_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_A        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_B        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RC_FRAME_TYPE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_VALUE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_TOLERANCE = 3'd5;

  typedef struct packed {
    logic [7:0]  address_a;
    logic [7:0]  address_b;
    logic [5:0]  max_length;
    logic [7:0]  rc_frame_type;
    logic [10:0] center_value;
    logic [9:0]  center_tolerance;
  } cfg_t;

  // Pulses in the cycle the final byte of a frame is accepted.
  typedef struct packed {
    logic             good;
    logic             fail;
    logic             rc;
    logic [POS_W-1:0] total;
  } frame_done_t;

  typedef struct packed {
    logic idle;
    logic out_free;
  } dec_status_t;

endpackage
`default_nettype wire

// File: rtl/crsf_byte_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_byte_if
// Stream of received serial bytes, one byte per word.
// ----------------------------------------------------------------------------
interface crsf_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/crsf_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_result_if
// Stream of decoded channel and CRC failure results.
// ----------------------------------------------------------------------------
interface crsf_result_if ();
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic [4:0]  active_count;
  logic        signal_ok;
  logic        last;

  modport source (output valid, output kind, output channel_index, output channel_value,
                  output active_count, output signal_ok, output last, input ready);
  modport sink   (input valid, input kind, input channel_index, input channel_value,
                  input active_count, input signal_ok, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/crsf_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface crsf_cfg_if import crsf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/crsf_frame_receiver_unit.sv
`default_nettype none
// A non-final byte leaves the decoder idle; the next byte follows while the output is free.
// A byte that ends a frame with a bad CRC loads its failure word in that same cycle.
// A good frame of T bytes is copied through S_CRD and S_CWR for each byte; an RC frame then
// reads 22 store bytes through S_DRD, S_DAPP and S_EMIT, and the last channel word is loaded
// as the decoder returns to idle; input waits until then.
// Reset is synchronous and active high; the accepted store reads as zero after reset.
// ----------------------------------------------------------------------------
// crsf_frame_receiver_unit
// CRSF receiver frame parser with CRC-8 check and RC channel decode.
// ----------------------------------------------------------------------------
module crsf_frame_receiver_unit import crsf_pkg::*; #(
  parameter int FRAME_BYTES = 64,
  parameter int CHANNELS    = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  crsf_cfg_if.sink      cfg,
  crsf_byte_if.sink     rx,
  crsf_result_if.source res
);

  localparam int AW = $clog2(FRAME_BYTES);

  cfg_t          regs;
  frame_done_t   done;
  dec_status_t   status;
  logic [AW-1:0] work_addr;
  logic [7:0]    work_data;
  logic          take_ok;

  assign take_ok = status.idle && status.out_free;

  crsf_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  crsf_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .cfg     (regs),
    .take_ok (take_ok),
    .rd_addr (work_addr),
    .rd_data (work_data),
    .done    (done)
  );

  crsf_decoder #(
    .FRAME_BYTES (FRAME_BYTES),
    .CHANNELS    (CHANNELS)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .cfg       (regs),
    .done      (done),
    .work_addr (work_addr),
    .work_data (work_data),
    .status    (status)
  );

endmodule
`default_nettype wire

// File: rtl/crsf_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_cfg_regs
// Configuration register file; writes are always taken.
// ----------------------------------------------------------------------------
module crsf_cfg_regs import crsf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  crsf_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.address_a        <= 8'd200;
      regs.address_b        <= 8'd234;
      regs.max_length       <= 6'd62;
      regs.rc_frame_type    <= 8'd22;
      regs.center_value     <= 11'd992;
      regs.center_tolerance <= 10'd5;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ADDRESS_A:        regs.address_a        <= cfg.data[7:0];
        REG_ADDRESS_B:        regs.address_b        <= cfg.data[7:0];
        REG_MAX_LENGTH:       regs.max_length       <= cfg.data[5:0];
        REG_RC_FRAME_TYPE:    regs.rc_frame_type    <= cfg.data[7:0];
        REG_CENTER_VALUE:     regs.center_value     <= cfg.data[10:0];
        REG_CENTER_TOLERANCE: regs.center_tolerance <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/crsf_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_parser
// Byte parser: frame sync, length check, working frame memory and running
// CRC-8 (polynomial 0xD5) over type and payload.
// ----------------------------------------------------------------------------
module crsf_parser import crsf_pkg::*; #(
  parameter int  FRAME_BYTES = 64,
  localparam int AW          = $clog2(FRAME_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  crsf_byte_if.sink          rx,
  input  cfg_t               cfg,
  input  wire logic          take_ok,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data,
  output frame_done_t        done
);

  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] MAX_FIT  = 8'(FRAME_BYTES - 2);

  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]       work_mem [FRAME_BYTES];
  logic [POS_W-1:0] pos;
  logic [5:0]       flen;
  logic [7:0]       crc;
  logic [7:0]       type_byte;

  logic             accept;
  logic [7:0]       b;
  logic             is_addr;
  logic [7:0]       lim;
  logic             len_ok;
  logic             final_byte;
  logic             wr_en;
  logic [AW-1:0]    wr_idx;

  assign rx.ready = take_ok;
  assign accept   = rx.valid & rx.ready;
  assign b        = rx.rx_byte;
  assign is_addr  = (b == cfg.address_a) || (b == cfg.address_b);

  always_comb begin
    lim = ({2'b00, cfg.max_length} > MAX_FIT) ? MAX_FIT : {2'b00, cfg.max_length};
  end

  assign len_ok     = (b >= 8'd2) && (b <= lim);
  assign final_byte = (pos >= 7'd2) && (pos == ({1'b0, flen} + 7'd1));
  assign wr_en      = is_addr || ((pos != '0) && ((pos != 7'd1) || len_ok));
  assign wr_idx     = is_addr ? '0 : pos[AW-1:0];

  always_comb begin
    done.good  = accept && !is_addr && final_byte && (crc == b);
    done.fail  = accept && !is_addr && final_byte && (crc != b);
    done.rc    = (type_byte == cfg.rc_frame_type);
    done.total = pos + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      flen <= '0;
    end else if (accept) begin
      if (is_addr) begin
        pos <= 7'd1;
      end else if (pos == 7'd1) begin
        if (len_ok) begin
          flen <= b[5:0];
          pos  <= 7'd2;
        end else begin
          pos <= '0;
        end
      end else if (pos != '0) begin
        pos <= final_byte ? '0 : pos + 7'd1;
      end
    end
  end

  // The type byte starts the CRC; later payload bytes extend it.
  always_ff @(posedge clk) begin
    if (accept && !is_addr && !final_byte) begin
      if (pos == 7'd2) begin
        type_byte <= b;
        crc       <= crc8_step(8'h00, b);
      end else if (pos > 7'd2) begin
        crc <= crc8_step(crc, b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      work_mem[wr_idx] <= b;
    end
    rd_data <= work_mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/crsf_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_decoder
// Copies a good frame into the accepted store; for an RC frame it then unpacks
// the sixteen 11-bit channels from it. Channel and CRC failure words drive the result register.
// ----------------------------------------------------------------------------
module crsf_decoder import crsf_pkg::*; #(
  parameter int  FRAME_BYTES = 64,
  parameter int  CHANNELS    = 16,
  localparam int AW          = $clog2(FRAME_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  crsf_result_if.source      res,
  input  cfg_t               cfg,
  input  frame_done_t        done,
  output logic [AW-1:0]      work_addr,
  input  wire logic [7:0]    work_data,
  output dec_status_t        status
);

  localparam logic [POS_W-1:0] FB      = POS_W'(FRAME_BYTES);
  localparam logic [3:0]       LAST_CH = 4'(CHANNELS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CRD  = 6'b000010,
    S_CWR  = 6'b000100,
    S_DRD  = 6'b001000,
    S_DAPP = 6'b010000,
    S_EMIT = 6'b100000
  } dstate_t;

  dstate_t          state;
  logic [7:0]       acc_mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] acc_valid;
  logic [7:0]       acc_q;
  logic             acc_ok;

  logic [POS_W-1:0] cp;
  logic [POS_W-1:0] total;
  logic             rc;
  logic [POS_W-1:0] rp;
  logic [17:0]      bits;
  logic [4:0]       nbits;
  logic [3:0]       ch;
  logic [4:0]       tally;
  logic             link_ok;
  logic             out_valid;

  logic             out_free;
  logic             acc_we;
  logic             load_fail;
  logic             load_ch;
  logic [10:0]      v;
  logic [10:0]      gap;
  logic             act;
  logic [4:0]       tally_next;
  logic             is_last;
  logic [7:0]       byte_in;

  assign out_free        = !out_valid || res.ready;
  assign status.idle     = (state == S_IDLE);
  assign status.out_free = out_free;
  assign res.valid       = out_valid;

  assign work_addr = cp[AW-1:0];
  assign acc_we    = (state == S_CWR);
  assign load_fail = (state == S_IDLE) && done.fail;
  assign load_ch   = (state == S_EMIT) && (nbits >= 5'd11) && out_free;

  assign v          = bits[10:0];
  assign gap        = (v > cfg.center_value) ? (v - cfg.center_value) : (cfg.center_value - v);
  assign act        = gap > {1'b0, cfg.center_tolerance};
  assign tally_next = tally + {4'd0, act};
  assign is_last    = (ch == LAST_CH);
  assign byte_in    = acc_ok ? acc_q : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc_valid <= '0;
      out_valid <= 1'b0;
      link_ok   <= 1'b0;
      cp        <= '0;
      total     <= '0;
      rc        <= 1'b0;
      rp        <= '0;
      nbits     <= '0;
      ch        <= '0;
      tally     <= '0;
    end else begin
      out_valid <= load_fail || load_ch || (out_valid && !res.ready);
      unique case (state)
        S_IDLE: begin
          if (done.fail) begin
            link_ok <= 1'b0;
          end else if (done.good) begin
            cp    <= '0;
            total <= done.total;
            rc    <= done.rc;
            state <= S_CRD;
          end
        end
        S_CRD: begin
          state <= S_CWR;
        end
        S_CWR: begin
          acc_valid[cp[AW-1:0]] <= 1'b1;
          cp <= cp + 7'd1;
          if ((cp + 7'd1) != total) begin
            state <= S_CRD;
          end else if (rc) begin
            // Channel bits start at store byte 3.
            link_ok <= 1'b1;
            rp      <= 7'd3;
            nbits   <= '0;
            ch      <= '0;
            tally   <= '0;
            state   <= S_DRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DRD: begin
          state <= S_DAPP;
        end
        S_DAPP: begin
          nbits <= nbits + 5'd8;
          rp    <= rp + 7'd1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (nbits < 5'd11) begin
            state <= S_DRD;
          end else if (out_free) begin
            nbits <= nbits - 5'd11;
            ch    <= ch + 4'd1;
            tally <= tally_next;
            if (is_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Accepted store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[cp[AW-1:0]] <= work_data;
    end
    acc_q  <= acc_mem[rp[AW-1:0]];
    acc_ok <= (rp < FB) && acc_valid[rp[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if ((state == S_CWR) && ((cp + 7'd1) == total)) begin
      bits <= '0;
    end else if (state == S_DAPP) begin
      bits <= bits | (18'(byte_in) << nbits);
    end else if (load_ch) begin
      bits <= bits >> 11;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fail) begin
      res.kind          <= 1'b1;
      res.channel_index <= '0;
      res.channel_value <= '0;
      res.active_count  <= '0;
      res.signal_ok     <= 1'b0;
      res.last          <= 1'b1;
    end else if (load_ch) begin
      res.kind          <= 1'b0;
      res.channel_index <= ch;
      res.channel_value <= v;
      res.active_count  <= is_last ? tally_next : 5'd0;
      res.signal_ok     <= link_ok;
      res.last          <= is_last;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_crsf_frame_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_crsf_frame_receiver_unit
// Self-checking bench for the CRSF frame receiver. A byte-level model of the
// parser tracks every accepted serial byte and queues the channel and CRC
// failure words it must produce. Directed frames cover the corner cases, then
// random well-formed, corrupted, truncated and noisy frames run under several
// register settings, mostly with random idling on both streams.
// ----------------------------------------------------------------------------
package crsf_rx_model_pkg;
  import crsf_pkg::*;

  localparam int FRAME_BYTES = 64;
  localparam int CHANNELS    = 16;
  localparam logic [7:0] CRC_POLY = 8'hD5;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic        kind;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic [4:0]  active_count;
    logic        signal_ok;
    logic        last;
  } result_word_t;

  class frame_scoreboard;
    cfg_t         regs;
    int unsigned  pos;
    int unsigned  flen;
    logic [7:0]   work_buf[FRAME_BYTES];
    logic [7:0]   store[FRAME_BYTES];
    logic         link_ok;
    logic [4:0]   tally;
    result_word_t due_words[$];
    int           errors;

    function new();
      regs.address_a        = 8'd200;
      regs.address_b        = 8'd234;
      regs.max_length       = 6'd62;
      regs.rc_frame_type    = 8'd22;
      regs.center_value     = 11'd992;
      regs.center_tolerance = 10'd5;
      pos     = 0;
      flen    = 0;
      link_ok = 1'b0;
      tally   = '0;
      errors  = 0;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ADDRESS_A:        regs.address_a        = val[7:0];
        REG_ADDRESS_B:        regs.address_b        = val[7:0];
        REG_MAX_LENGTH:       regs.max_length       = val[5:0];
        REG_RC_FRAME_TYPE:    regs.rc_frame_type    = val[7:0];
        REG_CENTER_VALUE:     regs.center_value     = val[10:0];
        REG_CENTER_TOLERANCE: regs.center_tolerance = val[9:0];
        default: ;
      endcase
    endfunction

    // The length byte may never ask for more than the frame store holds.
    function int unsigned len_limit();
      return (regs.max_length > FRAME_BYTES - 2) ? FRAME_BYTES - 2 : regs.max_length;
    endfunction

    static function logic [7:0] crc_d5(input byte_q_t data);
      logic [7:0] c;
      int i, k;
      c = 8'h00;
      for (i = 0; i < data.size(); i++) begin
        c ^= data[i];
        for (k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // Returns 1 when the parser makes use of the byte, 0 when it is ignored.
    function bit note_byte(input logic [7:0] b);
      byte_q_t      body;
      result_word_t w;
      logic [10:0]  vals[CHANNELS];
      logic [23:0]  win;
      int unsigned  total, bitpos, at, gap, n, i;
      if (b == regs.address_a || b == regs.address_b) begin
        work_buf[0] = b;
        pos = 1;
        return 1'b1;
      end
      if (pos == 0) return 1'b0;
      if (pos == 1) begin
        if (b < 2 || b > len_limit()) begin
          pos = 0;
          return 1'b1;
        end
        flen = b;
        work_buf[1] = b;
        pos = 2;
      end else begin
        work_buf[pos] = b;
        pos++;
      end
      total = flen + 2;
      if (pos != total) return 1'b1;
      pos = 0;

      for (i = 2; i <= flen; i++) body.push_back(work_buf[i]);
      w = '0;
      if (crc_d5(body) != work_buf[flen + 1]) begin
        link_ok = 1'b0;
        w.kind = 1'b1;
        w.last = 1'b1;
        due_words.push_back(w);
        return 1'b1;
      end
      for (i = 0; i < total; i++) store[i] = work_buf[i];
      if (work_buf[2] != regs.rc_frame_type) return 1'b1;

      // Channels are packed LSB first from store byte 3; a short frame leaves
      // older store bytes in place for the upper channels.
      link_ok = 1'b1;
      n = 0;
      for (i = 0; i < CHANNELS; i++) begin
        bitpos  = 11 * i;
        at      = 3 + bitpos / 8;
        win     = {store[at + 2], store[at + 1], store[at]};
        vals[i] = 11'(win >> (bitpos % 8));
        gap     = (vals[i] > regs.center_value) ? vals[i] - regs.center_value
                                                : regs.center_value - vals[i];
        if (gap > regs.center_tolerance) n++;
      end
      tally = 5'(n);
      for (i = 0; i < CHANNELS; i++) begin
        w.kind          = 1'b0;
        w.channel_index = 4'(i);
        w.channel_value = vals[i];
        w.active_count  = (i == CHANNELS - 1) ? tally : 5'd0;
        w.signal_ok     = link_ok;
        w.last          = (i == CHANNELS - 1);
        due_words.push_back(w);
      end
      return 1'b1;
    endfunction

    function void cmp_field(input string name, input logic [10:0] want,
                            input logic [10:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_word(input result_word_t seen);
      result_word_t want;
      if (due_words.size() == 0) begin
        $error("unexpected result word: kind %0d channel_index %0d",
               seen.kind, seen.channel_index);
        errors++;
        return;
      end
      want = due_words.pop_front();
      cmp_field("kind", want.kind, seen.kind);
      cmp_field("channel_index", want.channel_index, seen.channel_index);
      cmp_field("channel_value", want.channel_value, seen.channel_value);
      cmp_field("active_count", want.active_count, seen.active_count);
      cmp_field("signal_ok", want.signal_ok, seen.signal_ok);
      cmp_field("last", want.last, seen.last);
    endfunction
  endclass

endpackage

module tb_crsf_frame_receiver_unit;
  import crsf_pkg::*;
  import crsf_rx_model_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int HOLD_OFF       = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 90;

  logic clk;
  logic rst;
  bit   calm;
  int unsigned useful;
  int   idle_cycles;

  frame_scoreboard sb;

  crsf_cfg_if    cfg_ch ();
  crsf_byte_if   rx_ch ();
  crsf_result_if res_ch ();

  crsf_frame_receiver_unit dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_word({res_ch.kind, res_ch.channel_index, res_ch.channel_value,
                     res_ch.active_count, res_ch.signal_ok, res_ch.last});
    end
  end

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_data(input bit avoid_addr);
    logic [7:0] v;
    v = 8'($urandom_range(255));
    while (avoid_addr && (v == sb.regs.address_a || v == sb.regs.address_b))
      v = 8'($urandom_range(255));
    return v;
  endfunction

  // Valid stays high after a word is taken so back-to-back words never
  // lower and raise it in the same step.
  task automatic put_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 18) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    if (sb.note_byte(b)) useful++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [7:0] addr_a, input logic [7:0] addr_b,
                                input logic [5:0] max_len, input logic [7:0] rc_type,
                                input logic [10:0] center, input logic [9:0] tol);
    write_reg(REG_ADDRESS_A, CFG_DATA_W'(addr_a));
    write_reg(REG_ADDRESS_B, CFG_DATA_W'(addr_b));
    write_reg(REG_MAX_LENGTH, CFG_DATA_W'(max_len));
    write_reg(REG_RC_FRAME_TYPE, CFG_DATA_W'(rc_type));
    write_reg(REG_CENTER_VALUE, center);
    write_reg(REG_CENTER_TOLERANCE, CFG_DATA_W'(tol));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic settle();
    drain_results();
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Sends address, length, type, payload and CRC; flip corrupts the CRC and a
  // nonzero cut stops the frame after that many bytes.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] typ,
                            input byte_q_t body, input logic [7:0] flip,
                            input int unsigned cut);
    byte_q_t     frame_q;
    byte_q_t     crc_in;
    int unsigned n, i;
    crc_in = body;
    crc_in.push_front(typ);
    frame_q.push_back(addr);
    frame_q.push_back(8'(body.size() + 2));
    frame_q.push_back(typ);
    foreach (body[k]) frame_q.push_back(body[k]);
    frame_q.push_back(frame_scoreboard::crc_d5(crc_in) ^ flip);
    n = (cut == 0) ? frame_q.size() : cut;
    for (i = 0; i < n; i++) put_byte(frame_q[i]);
  endtask

  task automatic send_random_frame();
    byte_q_t     body;
    logic [7:0]  addr, typ, flip;
    int unsigned lim, len, cut, mode, i;
    bit          rc;
    lim  = sb.len_limit();
    addr = $urandom_range(1) ? sb.regs.address_a : sb.regs.address_b;
    rc   = ($urandom_range(99) < 60);
    typ  = rc ? sb.regs.rc_frame_type : pick_data(1'b1);
    if (rc && lim >= 24 && $urandom_range(3) != 0) len = 24;
    else if ($urandom_range(9) == 0) len = lim;
    else len = $urandom_range(2, (lim < 10) ? lim : 10);
    mode = $urandom_range(19);
    for (i = 0; i + 2 < len; i++) begin
      case (mode)
        0:       body.push_back(8'hFF);
        1:       body.push_back(8'h00);
        default: body.push_back(pick_data($urandom_range(9) != 0));
      endcase
    end
    flip = ($urandom_range(99) < 12) ? 8'($urandom_range(255, 1)) : 8'h00;
    cut  = ($urandom_range(99) < 6) ? $urandom_range(len + 1, 1) : 0;
    send_frame(addr, typ, body, flip, cut);
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned stop, roll;
    stop = useful + n_items;
    while (useful < stop) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        put_byte(8'($urandom_range(255)));
      end else if (roll < 9) begin
        // Address followed by a length byte outside the accepted range.
        put_byte($urandom_range(1) ? sb.regs.address_a : sb.regs.address_b);
        put_byte($urandom_range(1) ? 8'($urandom_range(1))
                                   : 8'($urandom_range(255, sb.len_limit() + 1)));
      end else if (roll < 11) begin
        drain_results();
      end else begin
        send_random_frame();
      end
    end
  endtask

  task automatic directed_frames();
    byte_q_t pay;
    // Noise before any address byte is ignored.
    put_byte(8'h00);
    put_byte(8'hFF);
    // Shortest RC frame: the channels come from its CRC byte and the cleared store.
    pay.delete();
    send_frame(sb.regs.address_a, sb.regs.rc_frame_type, pay, 8'h00, 0);
    // Bad CRC gives a single failure word.
    pay = {8'hA5};
    send_frame(sb.regs.address_b, sb.regs.rc_frame_type, pay, 8'h5A, 0);
    // Length bytes below and above the accepted range drop the frame.
    put_byte(sb.regs.address_a);
    put_byte(8'd1);
    put_byte(sb.regs.address_a);
    put_byte(8'd63);
    put_byte(8'h11);
    // A good frame of another type is only stored.
    pay = {8'h01, 8'h02};
    send_frame(sb.regs.address_b, 8'h10, pay, 8'h00, 0);
    // An address byte inside a frame restarts it.
    put_byte(sb.regs.address_a);
    put_byte(8'd5);
    put_byte(sb.regs.rc_frame_type);
    pay = {8'h55};
    send_frame(sb.regs.address_b, sb.regs.rc_frame_type, pay, 8'h00, 0);
  endtask

  initial begin
    logic [7:0] a_sel, b_sel;
    sb            = new();
    clk           = 1'b0;
    rst           = 1'b1;
    calm          = 1'b0;
    useful        = 0;
    idle_cycles   = 0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_ADDRESS_A;
    cfg_ch.data   = '0;
    res_ch.ready  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    directed_frames();
    settle();

    // Reset settings with both streams running flat out.
    calm = 1'b1;
    random_phase(PHASE_ITEMS);
    settle();
    calm = 1'b0;

    apply_settings(8'h00, 8'hFF, 6'd62, 8'h01, 11'd0, 10'd0);
    random_phase(PHASE_ITEMS);
    settle();

    apply_settings(8'h7F, 8'h80, 6'd30, 8'h00, 11'd2047, 10'd1023);
    random_phase(PHASE_ITEMS);
    settle();

    // Only frames with a length byte of 2 fit, so every RC frame is a short one.
    a_sel = 8'($urandom_range(126, 1));
    b_sel = 8'($urandom_range(254, 129));
    apply_settings(a_sel, b_sel, 6'd2, 8'hFF, 11'($urandom_range(2047)),
                   10'($urandom_range(1023)));
    random_phase(PHASE_ITEMS);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
